// ===== rtl/rotary_encoder_button_frontend_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the knob front end
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_BUTTON_FRONTEND_CORE_MACROS_SVH
`define ROTARY_ENCODER_BUTTON_FRONTEND_CORE_MACROS_SVH

// plain invariant, checked every cycle outside reset
`define REBF_ASSERT_ALWAYS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define REBF_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define REBF_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rebf_pkg.sv =====
// ----------------------------------------------------------------------------
// rebf_pkg
// Types, codes and the quadrature table shared by the knob front end.
// ----------------------------------------------------------------------------
package rebf_pkg;

   localparam int ROTATION_BITS_DEFAULT = 16;
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      CMD_ENCODER = 2'd0,
      CMD_SWITCH  = 2'd1,
      CMD_TICK    = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      CLICK_NONE   = 3'd0,
      CLICK_SINGLE = 3'd1,
      CLICK_DOUBLE = 3'd2,
      CLICK_TRIPLE = 3'd3,
      CLICK_LONG   = 3'd4
   } click_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE_MS      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LONG_PRESS_MS    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_STABLE_TICKS     = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_INACTIVITY_LIMIT = 2'd3;

   localparam logic [9:0]  DEBOUNCE_MS_RESET      = 10'd50;
   localparam logic [15:0] LONG_PRESS_MS_RESET    = 16'd2000;
   localparam logic [3:0]  STABLE_TICKS_RESET     = 4'd6;
   localparam logic [15:0] INACTIVITY_LIMIT_RESET = 16'd36000;

   localparam logic [3:0] CLICKS_MAX = 4'd15;

   // table entry: [5:4] detent event, [2:0] next state
   localparam logic [1:0] EV_NONE = 2'b00;
   localparam logic [1:0] EV_CW   = 2'b01;
   localparam logic [1:0] EV_CCW  = 2'b10;

   localparam logic [5:0] QUAD_TABLE [8][4] = '{
      '{6'h00, 6'h02, 6'h04, 6'h00},
      '{6'h03, 6'h00, 6'h01, 6'h10},
      '{6'h03, 6'h02, 6'h00, 6'h00},
      '{6'h03, 6'h02, 6'h01, 6'h00},
      '{6'h06, 6'h00, 6'h04, 6'h00},
      '{6'h06, 6'h05, 6'h00, 6'h20},
      '{6'h06, 6'h05, 6'h04, 6'h00},
      '{6'h00, 6'h02, 6'h04, 6'h00}
   };

   typedef struct packed {
      cmd_type     cmd;
      logic        clk_level;
      logic        dt_level;
      logic        switch_level;
      logic [15:0] time_ms;
   } req_item_type;

   typedef struct packed {
      logic signed [1:0]  step;
      logic signed [15:0] rotation_total;
      click_type          click_event;
      logic [15:0]        idle_ticks;
      logic               switch_state;
   } rsp_item_type;

   typedef struct packed {
      logic [9:0]  debounce_ms;
      logic [15:0] long_press_ms;
      logic [3:0]  stable_ticks;
      logic [15:0] inactivity_limit;
   } cfg_type;

endpackage

// ===== rtl/rebf_update.sv =====
// ----------------------------------------------------------------------------
// rebf_update
// Knob and switch state with its combinational next-state and result logic.
// ----------------------------------------------------------------------------
`include "rotary_encoder_button_frontend_core_macros.svh"

module rebf_update #(
   parameter int ROTATION_BITS = rebf_pkg::ROTATION_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_i,
   input  rebf_pkg::req_item_type item_i,
   input  rebf_pkg::cfg_type     cfg_i,
   output rebf_pkg::rsp_item_type rsp_o
);
   import rebf_pkg::*;

   logic [2:0]  quad_ff, quad_in;
   logic        sw_ff, sw_in;
   logic [15:0] last_ff, last_in;
   logic [3:0]  pend_ff, pend_in;
   logic [3:0]  prev_ff, prev_in;
   logic [3:0]  stable_ff, stable_in;
   logic [15:0] inact_ff, inact_in;
   logic signed [ROTATION_BITS-1:0] rot_ff, rot_in;

   logic [5:0]        quad_entry;
   logic [15:0]       delta;
   logic [3:0]        stable_inc;
   logic signed [1:0] step;
   click_type         click;

   always_comb begin
      quad_in    = quad_ff;
      sw_in      = sw_ff;
      last_in    = last_ff;
      pend_in    = pend_ff;
      prev_in    = prev_ff;
      stable_in  = stable_ff;
      inact_in   = inact_ff;
      rot_in     = rot_ff;
      step       = 2'sd0;
      click      = CLICK_NONE;
      quad_entry = QUAD_TABLE[quad_ff][{item_i.clk_level, item_i.dt_level}];
      delta      = item_i.time_ms - last_ff;
      stable_inc = stable_ff + 4'd1;
      if (valid_i) begin
         unique case (item_i.cmd)
            CMD_ENCODER: begin
               quad_in  = quad_entry[2:0];
               inact_in = '0;
               if (quad_entry[5:4] == EV_CW) begin
                  rot_in = rot_ff + ROTATION_BITS'(1);
                  step   = 2'sd1;
               end else if (quad_entry[5:4] == EV_CCW) begin
                  rot_in = rot_ff - ROTATION_BITS'(1);
                  step   = -2'sd1;
               end
            end
            CMD_SWITCH: begin
               // drop bounces and changes to the level already held
               if (delta >= {6'd0, cfg_i.debounce_ms} && item_i.switch_level != sw_ff) begin
                  last_in = item_i.time_ms;
                  sw_in   = item_i.switch_level;
                  if (item_i.switch_level) begin
                     inact_in = '0;
                     if (delta > cfg_i.long_press_ms) begin
                        click   = CLICK_LONG;
                        pend_in = '0;
                     end else if (pend_ff < CLICKS_MAX) begin
                        pend_in = pend_ff + 4'd1;
                     end
                  end
               end
            end
            CMD_TICK: begin
               if (inact_ff < cfg_i.inactivity_limit) begin
                  inact_in = inact_ff + 16'd1;
               end
               if (pend_ff != 4'd0) begin
                  if (prev_ff == pend_ff) begin
                     stable_in = stable_inc;
                     if (stable_inc == cfg_i.stable_ticks) begin
                        stable_in = '0;
                        pend_in   = '0;
                        priority if (pend_ff > 4'd2) click = CLICK_TRIPLE;
                        else if (pend_ff == 4'd2)    click = CLICK_DOUBLE;
                        else                         click = CLICK_SINGLE;
                     end
                  end else begin
                     prev_in   = pend_ff;
                     stable_in = '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff   <= '0;
         sw_ff     <= 1'b1;
         last_ff   <= '0;
         pend_ff   <= '0;
         prev_ff   <= '0;
         stable_ff <= '0;
         inact_ff  <= '0;
         rot_ff    <= '0;
      end else begin
         quad_ff   <= quad_in;
         sw_ff     <= sw_in;
         last_ff   <= last_in;
         pend_ff   <= pend_in;
         prev_ff   <= prev_in;
         stable_ff <= stable_in;
         inact_ff  <= inact_in;
         rot_ff    <= rot_in;
      end
   end

   always_comb begin
      rsp_o.step           = step;
      rsp_o.rotation_total = 16'(rot_in);
      rsp_o.click_event    = click;
      rsp_o.idle_ticks     = inact_in;
      rsp_o.switch_state   = sw_in;
   end

   `REBF_ASSERT_IMPLY(a_step_from_encoder, step != 2'sd0, valid_i && item_i.cmd == CMD_ENCODER, "detent without encoder request")
   `REBF_ASSERT_IMPLY(a_long_on_release, click == CLICK_LONG, valid_i && item_i.cmd == CMD_SWITCH && item_i.switch_level && !sw_ff, "long click without release")
   `REBF_ASSERT_NEXT(a_classify_clears, valid_i && item_i.cmd == CMD_TICK && click != CLICK_NONE, pend_ff == 4'd0 && stable_ff == 4'd0, "classified clicks left pending")

endmodule

// ===== rtl/rebf_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// rebf_rsp_queue
// Two-entry result buffer that decouples the update stage from the receiver.
// ----------------------------------------------------------------------------
`include "rotary_encoder_button_frontend_core_macros.svh"

module rebf_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_i,
   input  rebf_pkg::rsp_item_type push_data_i,
   input  logic                   pop_i,
   output logic                   valid_o,
   output rebf_pkg::rsp_item_type data_o,
   output logic [1:0]             count_o
);
   import rebf_pkg::*;

   rsp_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_i ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_i  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_i} - {1'b0, pop_i};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         entry_ff[wr_ptr_ff] <= push_data_i;
      end
   end

   assign valid_o = (count_ff != 2'd0);
   assign data_o  = entry_ff[rd_ptr_ff];
   assign count_o = count_ff;

   `REBF_ASSERT_IMPLY(a_no_overflow, push_i && !pop_i, count_ff < 2'd2, "result buffer overflow")
   `REBF_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_ff == $past(count_ff) + 2'd1, "count missed a push")
   `REBF_ASSERT_NEXT(a_count_down, pop_i && !push_i, count_ff == $past(count_ff) - 2'd1, "count missed a pop")

endmodule

// ===== rtl/rotary_encoder_button_frontend_core.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_button_frontend_core
// Rotary knob and push switch front end: quadrature decode, debounce, clicks.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream: req_tuser carries the kind (encoder pin
// change, switch change with millisecond stamp, 100 ms tick), req_tdata the
// pin levels and the stamp. Every request yields exactly one response on the
// rsp_ stream with the step, the running rotation count, any click event, the
// inactivity tick count and the debounced switch level.
// A request is captured into an input register, the state update and result
// are computed in the next cycle and written into a two-entry result buffer,
// so a response passes through the input register and a buffer entry, and
// rsp_tvalid is decoded from the registered buffer count.
// One request per cycle is taken in steady state while the receiver keeps up;
// the combinational state update in rebf_update sets that rate.
// When the receiver stalls, results collect in the buffer and req_tready drops
// once the input register and the buffer hold two results between them; it
// rises in the same cycle a response is taken.
// Reset initialises the state and loads the defaults; the csr_ port writes
// a setting at any edge with csr_we high and should be used while idle.
// ----------------------------------------------------------------------------
module rotary_encoder_button_frontend_core #(
   parameter int ROTATION_BITS = rebf_pkg::ROTATION_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [0] clk_level, [1] dt_level, [2] switch_level, [18:3] time_ms, rest zero
   input  logic [rebf_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] cmd
   input  logic [rebf_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] step, [17:2] rotation_total, [20:18] click_event,
   // [36:21] idle_ticks, [37] switch_state, rest zero
   output logic [rebf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [rebf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rebf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rebf_pkg::*;

   cfg_type      cfg_ff;
   logic         in_valid_ff, in_valid_in;
   req_item_type item_ff;
   rsp_item_type result;
   rsp_item_type head;
   logic [1:0]   rsp_count;
   logic [1:0]   occupancy;
   logic         rsp_pop;
   logic         req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= DEBOUNCE_MS_RESET;
         cfg_ff.long_press_ms    <= LONG_PRESS_MS_RESET;
         cfg_ff.stable_ticks     <= STABLE_TICKS_RESET;
         cfg_ff.inactivity_limit <= INACTIVITY_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DEBOUNCE_MS:      cfg_ff.debounce_ms      <= csr_wdata[9:0];
            CSR_LONG_PRESS_MS:    cfg_ff.long_press_ms    <= csr_wdata;
            CSR_STABLE_TICKS:     cfg_ff.stable_ticks     <= csr_wdata[3:0];
            CSR_INACTIVITY_LIMIT: cfg_ff.inactivity_limit <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register plus buffer entries never exceed two once pops are counted
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign occupancy  = rsp_count + {1'b0, in_valid_ff};
   assign req_tready = (occupancy < 2'd2) || rsp_pop;
   assign req_take   = req_tvalid && req_tready;
   assign in_valid_in = req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.cmd          <= cmd_type'(req_tuser[1:0]);
         item_ff.clk_level    <= req_tdata[0];
         item_ff.dt_level     <= req_tdata[1];
         item_ff.switch_level <= req_tdata[2];
         item_ff.time_ms      <= req_tdata[18:3];
      end
   end

   rebf_update #(
      .ROTATION_BITS(ROTATION_BITS)
   ) u_update (
      .clock  (clock),
      .reset  (reset),
      .valid_i(in_valid_ff),
      .item_i (item_ff),
      .cfg_i  (cfg_ff),
      .rsp_o  (result)
   );

   rebf_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_i     (in_valid_ff),
      .push_data_i(result),
      .pop_i      (rsp_pop),
      .valid_o    (rsp_tvalid),
      .data_o     (head),
      .count_o    (rsp_count)
   );

   assign rsp_tdata = {2'b00, head.switch_state, head.idle_ticks, head.click_event,
                       head.rotation_total, head.step};

endmodule
